>>> rtl/core/sstf_pkg.sv
// scan-line span table: shared types and constants
// used by every module of the block and by its checker
package sstf_pkg;

   localparam int COORD_W = 9;
   localparam int OUT_W = 10;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_EDGE  = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_RSVD  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      TOP_NONE   = 2'd0,
      TOP_READ   = 2'd1,
      TOP_UPDATE = 2'd2,
      TOP_CLEAR  = 2'd3
   } tbl_op_type;

   typedef struct packed {
      tbl_op_type           op;
      logic [COORD_W-1:0]   xi;
   } tbl_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_QRESP = 5'b10000
   } state_type;

endpackage

>>> rtl/core/sstf_div.sv
// slope divider: restoring division, one quotient bit per cycle
// depends on sstf_pkg
module sstf_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [sstf_pkg::COORD_W-1:0]          mag,
   input  logic [sstf_pkg::COORD_W-1:0]          den,
   output logic                                  done,
   output logic [sstf_pkg::COORD_W+FRAC_BITS-1:0] quot
);
   import sstf_pkg::*;

   localparam int QW = COORD_W + FRAC_BITS;
   localparam int CNTW = $clog2(QW + 1);

   logic [QW-1:0]      nq_ff, nq_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W-1:0] den_ff, den_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COORD_W:0]   trial;
   logic               fit;

   always_comb begin
      trial = {rem_ff, nq_ff[QW-1]};
      fit = trial >= {1'b0, den_ff};
      nq_in = nq_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         nq_in = {mag, {FRAC_BITS{1'b0}}};
         rem_in = '0;
         den_in = den;
         cnt_in = CNTW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         nq_in = {nq_ff[QW-2:0], fit};
         rem_in = fit ? COORD_W'(trial - {1'b0, den_ff}) : trial[COORD_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      nq_ff <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = nq_ff;

endmodule

>>> rtl/core/sstf_table.sv
// span memory: left and right entry per row, read-modify-write with forwarding
// depends on sstf_pkg
module sstf_table #(
   parameter int ROWS  = 512,
   parameter int WIDTH = 512,
   parameter int CW    = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sstf_pkg::tbl_cmd_type      cmd,
   input  logic [$clog2(ROWS)-1:0]    addr,
   output logic [CW-1:0]              rd_left,
   output logic [CW-1:0]              rd_right
);
   import sstf_pkg::*;

   localparam int RW = $clog2(ROWS);

   logic [2*CW-1:0]    span_mem [ROWS];
   logic [2*CW-1:0]    rd_q_ff;
   logic [2*CW-1:0]    fwd_q_ff, fwd_q_in;
   logic               fwd_hit_ff, fwd_hit_in;
   logic               p_upd_ff, p_upd_in;
   logic [RW-1:0]      p_addr_ff;
   logic [COORD_W-1:0] p_xi_ff;
   logic               rd_en, wr_en;
   logic [RW-1:0]      wr_addr;
   logic [2*CW-1:0]    wr_data;
   logic [CW-1:0]      cur_left, cur_right, xi_ext, new_left, new_right;

   always_comb begin
      rd_en = (cmd.op == TOP_READ) || (cmd.op == TOP_UPDATE);
      p_upd_in = (cmd.op == TOP_UPDATE);
      cur_left = fwd_hit_ff ? fwd_q_ff[2*CW-1:CW] : rd_q_ff[2*CW-1:CW];
      cur_right = fwd_hit_ff ? fwd_q_ff[CW-1:0] : rd_q_ff[CW-1:0];
      xi_ext = CW'(p_xi_ff);
      new_left = (xi_ext < cur_left) ? xi_ext : cur_left;
      new_right = (xi_ext > cur_right) ? xi_ext : cur_right;
      wr_en = p_upd_ff || (cmd.op == TOP_CLEAR);
      wr_addr = p_upd_ff ? p_addr_ff : addr;
      wr_data = p_upd_ff ? {new_left, new_right} : {CW'(WIDTH), {CW{1'b0}}};
      fwd_hit_in = wr_en && (wr_addr == addr);
      fwd_q_in = wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         span_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= span_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_upd_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         p_upd_ff <= p_upd_in;
         if (rd_en) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
      if (rd_en) begin
         p_addr_ff <= addr;
         p_xi_ff <= cmd.xi;
         fwd_q_ff <= fwd_q_in;
      end
   end

   assign rd_left = cur_left;
   assign rd_right = cur_right;

endmodule

>>> rtl/core/scanline_span_table_fill.sv
// Scan-line span table. One request at a time. A clear request writes every memory row,
// one memory row per cycle; the same clearing pass runs after reset, during which no
// request is taken. An edge request runs the slope divider, which yields one quotient bit
// per cycle, then the row walk, which updates one memory row per cycle; a horizontal edge
// skips the divider. A query reads one memory row and holds its result until the response
// register is free. The result register frees the input side, so a new request can be
// taken while a result waits to be taken.
module scanline_span_table_fill #(
   parameter int ROWS      = 512,
   parameter int WIDTH     = 512,
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_func,
   input  logic [sstf_pkg::COORD_W-1:0]   req_xa,
   input  logic [sstf_pkg::COORD_W-1:0]   req_ya,
   input  logic [sstf_pkg::COORD_W-1:0]   req_xb,
   input  logic [sstf_pkg::COORD_W-1:0]   req_yb,
   input  logic [sstf_pkg::COORD_W-1:0]   req_row,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sstf_pkg::OUT_W-1:0]     rsp_span_left,
   output logic [sstf_pkg::OUT_W-1:0]     rsp_span_right,
   output logic                           rsp_span_nonempty
);
   import sstf_pkg::*;

   localparam int RW = $clog2(ROWS);
   localparam int EW = $clog2(WIDTH + 1);
   localparam int CW = (EW > COORD_W) ? EW : COORD_W;
   localparam int QW = COORD_W + FRAC_BITS;

   state_type          state_ff, state_in;
   logic [RW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [QW-1:0]      x_ff, x_in;
   logic [COORD_W-1:0] r_ff, r_in;
   logic [COORD_W-1:0] hi_y_ff, hi_y_in;
   logic               neg_ff, neg_in;
   logic               q_ok_ff, q_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [OUT_W-1:0]   rsp_right_ff, rsp_right_in;
   logic               rsp_ne_ff, rsp_ne_in;

   logic               accept;
   logic               swap;
   logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y, dy, mag;
   logic               div_start, div_done;
   logic [QW-1:0]      quot;
   tbl_cmd_type        cmd;
   logic [RW-1:0]      addr;
   logic [CW-1:0]      rd_left, rd_right, q_left, q_right;
   logic               out_free;

   sstf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (mag),
      .den   (dy),
      .done  (div_done),
      .quot  (quot)
   );

   sstf_table #(.ROWS(ROWS), .WIDTH(WIDTH), .CW(CW)) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .addr     (addr),
      .rd_left  (rd_left),
      .rd_right (rd_right)
   );

   always_comb begin
      req_stall = reset || (state_ff != ST_IDLE);
      accept = req_valid && !req_stall;
      swap = req_yb < req_ya;
      lo_x = swap ? req_xb : req_xa;
      hi_x = swap ? req_xa : req_xb;
      lo_y = swap ? req_yb : req_ya;
      hi_y = swap ? req_ya : req_yb;
      dy = hi_y - lo_y;
      mag = (hi_x < lo_x) ? (lo_x - hi_x) : (hi_x - lo_x);
      out_free = !rsp_valid_ff || !rsp_stall;
      q_left = q_ok_ff ? rd_left : CW'(WIDTH);
      q_right = q_ok_ff ? rd_right : '0;

      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      x_in = x_ff;
      r_in = r_ff;
      hi_y_in = hi_y_ff;
      neg_in = neg_ff;
      q_ok_in = q_ok_ff;
      div_start = 1'b0;
      cmd.op = TOP_NONE;
      cmd.xi = x_ff[FRAC_BITS +: COORD_W];
      addr = RW'(r_ff);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_ne_in = rsp_ne_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in = ST_CLEAR;
                  end
                  FUNC_EDGE: begin
                     x_in = {lo_x, {FRAC_BITS{1'b0}}};
                     r_in = lo_y;
                     hi_y_in = hi_y;
                     neg_in = hi_x < lo_x;
                     if (dy == '0) begin
                        state_in = ST_WALK;
                     end else begin
                        div_start = 1'b1;
                        state_in = ST_DIV;
                     end
                  end
                  FUNC_QUERY: begin
                     q_ok_in = 32'(req_row) < ROWS;
                     addr = RW'(req_row);
                     if (32'(req_row) < ROWS) begin
                        cmd.op = TOP_READ;
                     end
                     state_in = ST_QRESP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.op = TOP_CLEAR;
            addr = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == RW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (32'(r_ff) < ROWS) begin
               cmd.op = TOP_UPDATE;
            end
            x_in = neg_ff ? (x_ff - quot) : (x_ff + quot);
            r_in = r_ff + 1'b1;
            if (r_ff == hi_y_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in = OUT_W'(q_left);
               rsp_right_in = OUT_W'(q_right);
               rsp_ne_in = q_left < q_right;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         q_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         q_ok_ff <= q_ok_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
      hi_y_ff <= hi_y_in;
      neg_ff <= neg_in;
      rsp_left_ff <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_ne_ff <= rsp_ne_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_span_left = rsp_left_ff;
   assign rsp_span_right = rsp_right_ff;
   assign rsp_span_nonempty = rsp_ne_ff;

endmodule

>>> rtl/core/sstf_checker.sv
// port-level checks for the scan-line span table, bound to the top level
// depends on sstf_pkg and scanline_span_table_fill
module sstf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [1:0]                     req_func,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [sstf_pkg::OUT_W-1:0]     rsp_span_left,
   input logic [sstf_pkg::OUT_W-1:0]     rsp_span_right,
   input logic                           rsp_span_nonempty
);
   import sstf_pkg::*;

   // clearing pass follows reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open right after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func != FUNC_RSVD)) |=> req_stall)
      else $error("request taken while previous one still in work");

   // non-empty span needs a right edge above zero
   a_nonempty_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_span_nonempty) |-> (rsp_span_right != '0))
      else $error("non-empty span with zero right edge");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_span_left)
         && $stable(rsp_span_right) && $stable(rsp_span_nonempty)))
      else $error("stalled response changed");

endmodule

bind scanline_span_table_fill sstf_checker u_sstf_checker (.*);

>>> tb/sv/scanline_span_table_fill_chk.sv
// checker for the scan-line span table: keeps its own copy of the row tables,
// predicts each query response and compares it field by field with the block
// depends on sstf_pkg for the field widths and the request codes
module scanline_span_table_fill_chk #(
   parameter int ROWS      = 512,
   parameter int WIDTH     = 512,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_func,
   input  logic [sstf_pkg::COORD_W-1:0] req_xa,
   input  logic [sstf_pkg::COORD_W-1:0] req_ya,
   input  logic [sstf_pkg::COORD_W-1:0] req_xb,
   input  logic [sstf_pkg::COORD_W-1:0] req_yb,
   input  logic [sstf_pkg::COORD_W-1:0] req_row,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [sstf_pkg::OUT_W-1:0]   rsp_span_left,
   input  logic [sstf_pkg::OUT_W-1:0]   rsp_span_right,
   input  logic                         rsp_span_nonempty,
   output int                           errors,
   output int                           pending
);
   import sstf_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] left;
      logic [OUT_W-1:0] right;
      logic             nonempty;
   } span_type;

   logic [OUT_W-1:0] row_left [ROWS];
   logic [OUT_W-1:0] row_right [ROWS];
   span_type         expected_spans [$];
   span_type         want;
   int               fail_count = 0;

   task automatic wipe_tables();
      for (int r = 0; r < ROWS; r++) begin
         row_left[r] = OUT_W'(WIDTH);
         row_right[r] = '0;
      end
   endtask

   // walk the edge bottom-up in fixed point, widening each row it crosses
   task automatic trace_edge(input logic [COORD_W-1:0] xa, ya, xb, yb);
      longint lo_x, lo_y, hi_x, hi_y, dx, mag, slope, x;
      longint xi;
      lo_x = xa;
      lo_y = ya;
      hi_x = xb;
      hi_y = yb;
      if (yb < ya) begin
         lo_x = xb;
         lo_y = yb;
         hi_x = xa;
         hi_y = ya;
      end
      dx = hi_x - lo_x;
      mag = (dx < 0 ? -dx : dx) << FRAC_BITS;
      if (hi_y != lo_y)
         mag = mag / (hi_y - lo_y);
      slope = (dx < 0) ? -mag : mag;
      x = lo_x << FRAC_BITS;
      for (longint r = lo_y; r <= hi_y; r++) begin
         xi = (x > 0) ? (x >>> FRAC_BITS) : 0;
         if (r < ROWS) begin
            if (xi < row_left[r])
               row_left[r] = xi[OUT_W-1:0];
            if (xi > row_right[r])
               row_right[r] = xi[OUT_W-1:0];
         end
         x += slope;
      end
   endtask

   function automatic span_type span_of(input logic [COORD_W-1:0] row);
      span_type s;
      s.left = OUT_W'(WIDTH);
      s.right = '0;
      if (row < ROWS) begin
         s.left = row_left[row];
         s.right = row_right[row];
      end
      s.nonempty = (s.left < s.right);
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wipe_tables();
         expected_spans.delete();
      end else begin
         // responses first, so one arriving with nothing queued is never hidden
         if (rsp_valid && !rsp_stall) begin
            if (expected_spans.size() == 0) begin
               fail_count++;
               $error("response with no query waiting: left %0d right %0d nonempty %0d",
                      rsp_span_left, rsp_span_right, rsp_span_nonempty);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_span_left !== want.left) begin
                  fail_count++;
                  $error("span_left: expected %0d, got %0d", want.left, rsp_span_left);
               end
               if (rsp_span_right !== want.right) begin
                  fail_count++;
                  $error("span_right: expected %0d, got %0d", want.right, rsp_span_right);
               end
               if (rsp_span_nonempty !== want.nonempty) begin
                  fail_count++;
                  $error("span_nonempty: expected %0d, got %0d", want.nonempty,
                         rsp_span_nonempty);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (func_type'(req_func))
               FUNC_CLEAR: wipe_tables();
               FUNC_EDGE:  trace_edge(req_xa, req_ya, req_xb, req_yb);
               FUNC_QUERY: expected_spans.push_back(span_of(req_row));
               default: ;
            endcase
         end
      end
      errors <= fail_count;
      pending <= expected_spans.size();
   end

endmodule

>>> tb/sv/scanline_span_table_fill_tb.sv
// testbench top for the scan-line span table: clock, reset, request stimulus,
// response stalls and the verdict; needs scanline_span_table_fill, sstf_pkg
// and the checker scanline_span_table_fill_chk
module scanline_span_table_fill_tb;
   import sstf_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_func;
   logic [COORD_W-1:0] req_xa;
   logic [COORD_W-1:0] req_ya;
   logic [COORD_W-1:0] req_xb;
   logic [COORD_W-1:0] req_yb;
   logic [COORD_W-1:0] req_row;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [OUT_W-1:0]   rsp_span_left;
   logic [OUT_W-1:0]   rsp_span_right;
   logic               rsp_span_nonempty;
   int                 errors;
   int                 pending;

   bit calm = 1'b0;
   bit hold_rsp = 1'b0;
   int sent = 0;

   always #5 clock = ~clock;

   scanline_span_table_fill u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_xa            (req_xa),
      .req_ya            (req_ya),
      .req_xb            (req_xb),
      .req_yb            (req_yb),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_span_left     (rsp_span_left),
      .rsp_span_right    (rsp_span_right),
      .rsp_span_nonempty (rsp_span_nonempty)
   );

   scanline_span_table_fill_chk u_chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_xa            (req_xa),
      .req_ya            (req_ya),
      .req_xb            (req_xb),
      .req_yb            (req_yb),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_span_left     (rsp_span_left),
      .rsp_span_right    (rsp_span_right),
      .rsp_span_nonempty (rsp_span_nonempty),
      .errors            (errors),
      .pending           (pending)
   );

   function automatic logic [COORD_W-1:0] any9();
      return COORD_W'($urandom_range(0, 511));
   endfunction

   task automatic send_req(input func_type f, input logic [COORD_W-1:0] xa, ya, xb, yb, row);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_xa <= xa;
      req_ya <= ya;
      req_xb <= xb;
      req_yb <= yb;
      req_row <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic send_edge(input logic [COORD_W-1:0] xa, ya, xb, yb);
      send_req(FUNC_EDGE, xa, ya, xb, yb, any9());
   endtask

   task automatic send_query(input logic [COORD_W-1:0] row);
      send_req(FUNC_QUERY, any9(), any9(), any9(), any9(), row);
   endtask

   task automatic send_clear();
      send_req(FUNC_CLEAR, any9(), any9(), any9(), any9(), any9());
   endtask

   // polygon, usually closed, around a random center, then queries mostly over its rows
   task automatic run_scene();
      int n, cx, cy, rad, lo_x, hi_x, lo_y, hi_y;
      logic [COORD_W-1:0] vx [6];
      logic [COORD_W-1:0] vy [6];
      if ($urandom_range(0, 9) == 0)
         send_clear();
      n = $urandom_range(3, 6);
      cx = $urandom_range(0, 511);
      cy = $urandom_range(0, 511);
      rad = ($urandom_range(0, 5) == 0) ? 511 : $urandom_range(1, 40);
      lo_x = (cx > rad) ? cx - rad : 0;
      hi_x = (cx + rad > 511) ? 511 : cx + rad;
      lo_y = (cy > rad) ? cy - rad : 0;
      hi_y = (cy + rad > 511) ? 511 : cy + rad;
      for (int i = 0; i < n; i++) begin
         vx[i] = COORD_W'($urandom_range(lo_x, hi_x));
         vy[i] = COORD_W'($urandom_range(lo_y, hi_y));
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
               0: send_req(FUNC_RSVD, any9(), any9(), any9(), any9(), any9());
               1: send_edge(any9(), any9(), any9(), any9());
               default: send_query(any9());
            endcase
         end
         // occasionally leave the polygon open
         if ($urandom_range(0, 15) != 0)
            send_edge(vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n]);
      end
      repeat ($urandom_range(3, 8)) begin
         if ($urandom_range(0, 5) == 0)
            send_query(any9());
         else
            send_query(COORD_W'($urandom_range(lo_y, hi_y)));
      end
   endtask

   // response side: random stall bursts, one long hold when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      #30_000_000;
      $display("scanline_span_table_fill: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_CLEAR;
      req_xa = '0;
      req_ya = '0;
      req_xb = '0;
      req_yb = '0;
      req_row = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty table edges, then corner to corner diagonal
      send_query(9'd0);
      send_query(9'd511);
      send_req(FUNC_EDGE, 9'd0, 9'd0, 9'd511, 9'd511, 9'd0);
      send_query(9'd0);
      send_query(9'd511);
      send_query(9'd256);
      // endpoints given top first with x falling
      send_req(FUNC_EDGE, 9'd0, 9'd100, 9'd511, 9'd10, 9'd511);
      // horizontal and vertical edges
      send_edge(9'd5, 9'd300, 9'd400, 9'd300);
      send_edge(9'd511, 9'd200, 9'd511, 9'd205);
      send_req(FUNC_RSVD, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511);
      send_query(9'd300);
      send_query(9'd50);
      send_query(9'd203);
      send_req(FUNC_CLEAR, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511);
      send_query(9'd300);
      // single point edges at the corners
      send_edge(9'd0, 9'd511, 9'd0, 9'd511);
      send_edge(9'd511, 9'd0, 9'd511, 9'd0);
      send_query(9'd511);
      send_query(9'd0);
      send_req(FUNC_QUERY, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511);

      // long response hold while queries keep coming
      hold_rsp = 1'b1;
      repeat (16) send_query(any9());

      while (sent < 1170) begin
         if (sent >= 1020)
            calm = 1'b1;
         run_scene();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("scanline_span_table_fill: match");
      else
         $display("scanline_span_table_fill: mismatch");
      $finish;
   end

endmodule
